>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared payload types, round constants, initial hash values and a rotate function.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/sha_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 input queue
// Short register queue that separates the input port from the hash engine.
// ----------------------------------------------------------------------------
module sha_queue #(
  parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sha_pkg::in_word_t push_data,
  output logic             full,
  input  logic             pop,
  output sha_pkg::in_word_t pop_data,
  output logic             empty
);
  import sha_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_word_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop && !empty)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue pop did not lower count");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue push did not raise count");
`endif

endmodule

>>> rtl/sha_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 engine
// Block buffer held in the schedule registers, padding, 64-round compression
// and digest output.
// ----------------------------------------------------------------------------
module sha_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  sha_pkg::in_word_t item,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::out_word_t out_data
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]  state_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [6:0]  cnt_r;
  logic        fin_r;
  logic        second_r;
  logic [2:0]  oidx_r;

  // Round datapath: the schedule window shifts, w_r[0] is word r-16.
  logic [31:0] w_new, w_cur, t1, t2, e, a, s0, s1;
  always_comb begin
    s0 = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = (cnt_r < 7'd16) ? w_r[cnt_r[3:0]] : w_new;
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[cnt_r[5:0]] + w_cur;
    t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Word that holds the pad byte: earlier bytes kept, pad byte, zeros after.
  logic [31:0] pad_word;
  always_comb begin
    unique case (fill_r[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h000000};
      2'd1: pad_word = {w_r[fill_r[5:2]][31:24], PAD_BYTE, 16'h0000};
      2'd2: pad_word = {w_r[fill_r[5:2]][31:16], PAD_BYTE, 8'h00};
      2'd3: pad_word = {w_r[fill_r[5:2]][31:8], PAD_BYTE};
    endcase
  end

  assign item_pop  = (state_r == ST_IDLE) && item_valid;
  assign out_valid = (state_r == ST_EMIT);
  assign out_data.digest_word = h_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == 3'd7);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bits_r   <= '0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      oidx_r   <= '0;
      for (int j = 0; j < 8; j++) h_r[j] <= INIT_HASH[j];
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.mode == MODE_ABSORB) begin
              // Bytes land big-endian in the block words.
              unique case (fill_r[1:0])
                2'd0: w_r[fill_r[5:2]][31:24] <= item.data_byte;
                2'd1: w_r[fill_r[5:2]][23:16] <= item.data_byte;
                2'd2: w_r[fill_r[5:2]][15:8]  <= item.data_byte;
                2'd3: w_r[fill_r[5:2]][7:0]   <= item.data_byte;
              endcase
              bits_r <= bits_r + 64'd8;
              fill_r <= fill_r + 6'd1;
              fin_r  <= 1'b0;
              if (fill_r == 6'd63) state_r <= ST_LOAD;
            end else begin
              // Pad byte then zero fill to the end of the block.
              for (int j = 0; j < 16; j++) begin
                if (j == int'(fill_r[5:2])) w_r[j] <= pad_word;
                else if (j > int'(fill_r[5:2])) w_r[j] <= '0;
              end
              fin_r <= 1'b1;
              second_r <= (fill_r >= 6'd56);
              state_r <= (fill_r >= 6'd56) ? ST_LOAD : ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // Length field into the last two words.
          w_r[14] <= bits_r[63:32];
          w_r[15] <= bits_r[31:0];
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
          cnt_r <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          // The block after a full pad block starts as all zeros.
          if (cnt_r == 7'd63 && fin_r && second_r) begin
            for (int j = 0; j < 16; j++) w_r[j] <= '0;
          end else if (cnt_r >= 7'd16) begin
            for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
            w_r[15] <= w_new;
          end
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            for (int j = 0; j < 8; j++) begin
              if (j == 0) h_r[j] <= h_r[j] + t1 + t2;
              else if (j == 4) h_r[j] <= h_r[j] + v_r[3] + t1;
              else h_r[j] <= h_r[j] + v_r[j-1];
            end
            if (!fin_r) state_r <= ST_IDLE;
            else if (second_r) begin
              second_r <= 1'b0;
              state_r <= ST_PAD;
            end else begin
              oidx_r <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int j = 0; j < 8; j++) h_r[j] <= INIT_HASH[j];
              fill_r <= '0;
              bits_r <= '0;
              fin_r  <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> state_r == ST_IDLE) else $error("item taken while busy");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(oidx_r))
    else $error("digest word changed under stall");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> cnt_r < 7'd64) else $error("round count overrun");
`endif

endmodule

>>> rtl/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Front queue takes bytes and finish words; the engine hashes them.
// ----------------------------------------------------------------------------
// An absorb word is written into the block buffer; the 64th byte of a block adds
// a load step and the 64 rounds of the single shared round unit. A finish word
// runs one compression (two compressions when 56 or more bytes were buffered),
// then eight digest words, one per unstalled cycle. A four-word queue keeps
// accepting input while the engine works.
module sha256_byte_stream_hasher_top #(
  parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_word_t out_data
);
  import sha_pkg::*;

  logic     q_full, q_empty, q_pop;
  in_word_t q_data;

  assign in_stall = q_full;

  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(!q_empty), .item(q_data), .item_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

>>> tb/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, hashes accepted message bytes on its own and compares
// each digest word leaving the block with the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sha_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sha_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending_words,
  output int                 digest_count
);
  import sha_pkg::*;

  // Round constants, kept locally so the prediction does not lean on the RTL.
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  out_word_t   digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk into chain.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = w[j-16] + s0 + w[j-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
  endtask

  // Absorb a byte, or pad the message and queue its eight digest words.
  task automatic hash_word(input in_word_t iw);
    out_word_t ow;
    if (iw.mode == MODE_ABSORB) begin
      blk[fill] = iw.data_byte;
      bit_len = bit_len + 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress();
    end else begin
      blk[fill] = 8'h80;
      for (int j = int'(fill) + 1; j < 64; j++) blk[j] = 8'h00;
      // The length does not fit behind the pad: one extra block.
      if (fill >= 6'd56) begin
        compress();
        for (int j = 0; j < 56; j++) blk[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++) blk[56+j] = bit_len[63-8*j -: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        ow.digest_word = chain[j];
        ow.word_index  = 3'(j);
        ow.last_word   = (j == 7);
        digest_q.push_back(ow);
      end
      for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
      fill = '0;
      bit_len = '0;
      digest_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    digest_count = 0;
    pending_words = 0;
    fill = '0;
    bit_len = '0;
    for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
  end

  // Sample both handshakes at the clock edge.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) hash_word(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_data.digest_word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word) begin
            $error("digest_word expected %h actual %h", want.digest_word,
                   out_data.digest_word);
            fail_count++;
          end
          if (out_data.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index,
                   out_data.word_index);
            fail_count++;
          end
          if (out_data.last_word !== want.last_word) begin
            $error("last_word expected %0d actual %0d", want.last_word,
                   out_data.last_word);
            fail_count++;
          end
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

>>> tb/sha256_byte_stream_hasher_top_test.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher test
// Sends directed and random messages under three idling patterns and lets the
// checker compare every digest word with an independent hash.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top_test;
  import sha_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  int        fail_count;
  int        pending_words;
  int        digest_count;
  int        sent_words;
  int        send_idle_pct;
  int        recv_idle_pct;

  sha256_byte_stream_hasher_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sha256_digest_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_words(pending_words),
    .digest_count(digest_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random with the current idle percentage.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Send one word, idling at random first, and hold it until accepted.
  task automatic send_word(input logic mode, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.mode <= mode;
    in_data.data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_message(input int len, input bit rand_bytes,
                              input logic [7:0] fill_byte);
    for (int j = 0; j < len; j++)
      send_word(MODE_ABSORB, rand_bytes ? 8'($urandom) : fill_byte);
    send_word(MODE_FINISH, 8'($urandom));
  endtask

  // One idling phase of random messages, mostly short, some across blocks.
  task automatic random_phase(input int budget);
    int len, start;
    start = sent_words;
    while (sent_words - start < budget) begin
      case ($urandom_range(9))
        0:       len = $urandom_range(54, 65);
        1:       len = $urandom_range(66, 100);
        default: len = $urandom_range(0, 20);
      endcase
      send_message(len, 1'b1, 8'h00);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sent_words = 0;
    send_idle_pct = 18;
    recv_idle_pct = 73;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, single extreme bytes, short messages, pad edge at 55/56 bytes.
    send_message(0, 1'b0, 8'h00);
    send_message(1, 1'b0, 8'hff);
    send_message(1, 1'b0, 8'h00);
    send_message(3, 1'b1, 8'h00);
    send_message(10, 1'b0, 8'h55);
    send_message(55, 1'b1, 8'h00);
    send_message(56, 1'b1, 8'h00);

    random_phase(20);
    send_idle_pct = 73;
    recv_idle_pct = 18;
    random_phase(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(20);
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d words in %0d messages under three idling patterns.",
             sent_words, digest_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
